/* rtl/core/tf256_pkg.sv */
// ----------------------------------------------------------------------------
// tf256_pkg
// Types, constants and GF/permutation helpers of the Twofish-256 core.
// ----------------------------------------------------------------------------
`default_nettype none
package tf256_pkg;

   localparam int NumSubkeys = 40;
   localparam int KeyRegs    = 4;

   localparam logic CMD_ENCRYPT = 1'b0;
   localparam logic CMD_DECRYPT = 1'b1;

   localparam logic [1:0] CSR_KEY_PART0 = 2'd0;

   typedef struct packed {
      logic        command;
      logic [31:0] in_word0;
      logic [31:0] in_word1;
      logic [31:0] in_word2;
      logic [31:0] in_word3;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] out_word0;
      logic [31:0] out_word1;
      logic [31:0] out_word2;
      logic [31:0] out_word3;
   } rsp_payload_type;

   // key schedule to cipher datapath: subkey and S-box memory write ports
   typedef struct packed {
      logic        sk_we;
      logic [5:0]  sk_addr;
      logic [31:0] sk_data;
      logic        sb_we;
      logic [9:0]  sb_addr;
      logic [31:0] sb_data;
   } ks_write_type;

   function automatic logic [3:0] nib_rot(input logic [3:0] b);
      return {b[0], b[3:1]};
   endfunction

   function automatic logic [3:0] nib_shx(input logic [3:0] a);
      return {a[0], 3'b000} ^ a;
   endfunction

   // explicit nibble tables (index 0 in low nibble)
   function automatic logic [3:0] tsel(input logic [2:0] id, input logic [3:0] x);
      logic [63:0] t;
      case (id)
         3'd0:    t = 64'h4ACE95B023F6D718;
         3'd1:    t = 64'h5CA04913E67FDB82;
         3'd2:    t = 64'hD9076A4F53218BCE;
         3'd3:    t = 64'h809F5AD673C4B2E1;
         3'd4:    t = 64'h17423F8C09D6E5AB;
         3'd5:    t = 64'hF3B28DE0A96157C4;
         3'd6:    t = 64'hAC5803B9E6214F7D;
         default: t = 64'hA802F746ED3C159B;
      endcase
      return t[{x, 2'b00} +: 4];
   endfunction

   function automatic logic [7:0] qperm(input logic n, input logic [7:0] x);
      logic [3:0] a, b, a1, b1;
      a = x[7:4];
      b = x[3:0];
      for (int k = 0; k < 2; k++) begin
         a1 = a ^ b;
         b1 = nib_rot(b) ^ nib_shx(a);
         a  = tsel(3'((2*k)*2) | {2'b00, n}, a1);
         b  = tsel(3'((2*k+1)*2) | {2'b00, n}, b1);
      end
      return {b, a};
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] x;
      logic [7:0] r;
      x = {1'b0, a};
      r = 8'h0;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) r = r ^ x[7:0];
         x = {x[7:0], 1'b0};
         if (x[8]) x = x ^ 9'h169;
      end
      return r;
   endfunction

   function automatic logic [7:0] mds_m(input logic [1:0] i, input logic [1:0] j);
      logic [31:0] row;
      case (i)
         2'd0:    row = 32'h5B5BEF01;
         2'd1:    row = 32'h01EFEF5B;
         2'd2:    row = 32'hEF015BEF;
         default: row = 32'h5BEF01EF;
      endcase
      return row[{j, 3'b000} +: 8];
   endfunction

   function automatic logic qsel(input logic [2:0] s, input logic [1:0] j);
      logic [3:0] r;
      case (s)
         3'd0:    r = 4'b1001;
         3'd1:    r = 4'b0011;
         3'd2:    r = 4'b1010;
         3'd3:    r = 4'b1100;
         default: r = 4'b0101;
      endcase
      return r[j];
   endfunction

   // byte j of h for input byte y, key list k (k[3] used first)
   function automatic logic [31:0] h_byte(input logic [1:0] j, input logic [7:0] y0,
                                          input logic [127:0] k);
      logic [7:0]  y;
      logic [7:0]  z;
      logic [31:0] r;
      y = y0;
      for (int s = 0; s < 4; s++)
         y = qperm(qsel(3'(s), j), y) ^ k[(3-s)*32 + j*8 +: 8];
      z = qperm(qsel(3'd4, j), y);
      for (int i = 0; i < 4; i++)
         r[i*8 +: 8] = gf_mul(mds_m(2'(i), j), z);
      return r;
   endfunction

   function automatic logic [31:0] swap32(input logic [31:0] x);
      return {x[7:0], x[15:8], x[23:16], x[31:24]};
   endfunction

   function automatic logic [31:0] rs_rem(input logic [31:0] p0i, input logic [31:0] p1i);
      logic [31:0] p0, p1, t, u;
      p0 = p0i;
      p1 = p1i;
      for (int i = 0; i < 8; i++) begin
         t  = {24'h0, p1[31:24]};
         p1 = {p1[23:0], p0[31:24]};
         p0 = {p0[23:0], 8'h0};
         u  = {t[30:0], 1'b0};
         if (t[7]) u = u ^ 32'h14D;
         p1 = p1 ^ t ^ {u[15:0], 16'h0};
         u  = u ^ {1'b0, t[31:1]};
         if (t[0]) u = u ^ 32'hA6;
         p1 = p1 ^ {u[7:0], 24'h0} ^ {u[23:0], 8'h0};
      end
      return p1;
   endfunction

endpackage
`default_nettype wire

/* rtl/core/twofish_block_cipher_256_top.sv */
// From request transfer to rsp_valid: start, input whitening, 16 half-rounds
// (memory reads, then a compute step), output whitening.
// req_ready stays low until the result transfer, so blocks never overlap.
// After reset or any key write, key expansion runs when the next block
// arrives, before that block starts. Reset is synchronous and clears keys
// and control state.
// ----------------------------------------------------------------------------
// twofish_block_cipher_256_top
// Twofish-256 core with key registers, key expansion and round engine.
// ----------------------------------------------------------------------------
`default_nettype none
module twofish_block_cipher_256_top
   import tf256_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output rsp_payload_type rsp_payload,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [1:0] csr_index,
   input  wire logic [63:0] csr_data
);

   logic [63:0]     key_ff [KeyRegs];
   logic            ready_ff, busy_ff, ks_busy, ks_start, rd_start, done;
   logic            pend_ff;
   req_payload_type blk_ff;
   rsp_payload_type res;
   ks_write_type    wr;

   assign csr_ready = 1'b1;
   assign req_ready = !busy_ff;
   assign ks_start  = pend_ff && !ready_ff && !ks_busy;
   assign rd_start  = pend_ff && ready_ff && !ks_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KeyRegs; i++) key_ff[i] <= '0;
         ready_ff  <= 1'b0;
         busy_ff   <= 1'b0;
         pend_ff   <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         if (csr_valid) begin
            key_ff[csr_index] <= csr_data;
            ready_ff          <= 1'b0;
         end
         if (ks_start) ready_ff <= 1'b1;
         if (req_valid && req_ready) begin
            busy_ff <= 1'b1;
            pend_ff <= 1'b1;
         end
         if (rd_start) pend_ff <= 1'b0;
         if (done) rsp_valid <= 1'b1;
         if (rsp_valid && rsp_ready) begin
            rsp_valid <= 1'b0;
            busy_ff   <= 1'b0;
         end
      end
      if (req_valid && req_ready) blk_ff <= req_payload;
      if (done) rsp_payload <= res;
   end

   tf256_keysched u_ks (
      .clock (clock),
      .reset (reset),
      .start (ks_start),
      .key   ({key_ff[3], key_ff[2], key_ff[1], key_ff[0]}),
      .wr    (wr),
      .busy  (ks_busy)
   );

   tf256_round u_rnd (
      .clock (clock),
      .reset (reset),
      .wr    (wr),
      .start (rd_start),
      .blk   (blk_ff),
      .done  (done),
      .res   (res)
   );

   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> busy_ff)
      else $error("result without block");
   assert property (@(posedge clock) disable iff (reset) rd_start |-> !ks_busy)
      else $error("cipher start during key expansion");
   assert property (@(posedge clock) disable iff (reset) done |=> rsp_valid)
      else $error("result lost");

endmodule
`default_nettype wire

/* rtl/core/tf256_keysched.sv */
// ----------------------------------------------------------------------------
// tf256_keysched
// Key expansion sequencer: subkey pairs, then the keyed S-box table.
// ----------------------------------------------------------------------------
`default_nettype none
module tf256_keysched
   import tf256_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [255:0] key,
   output ks_write_type      wr,
   output logic              busy
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SUBA = 4'b0010,
      ST_SUBB = 4'b0100,
      ST_SBOX = 4'b1000
   } state_type;

   state_type   state_ff, state_in;
   logic [9:0]  cnt_ff, cnt_in;
   logic [31:0] a_ff, a_in, b_ff, b_in;
   logic [127:0] ev, od, skw;
   logic [7:0]  ib;
   logic [31:0] ha, hb, s0;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         ev[i*32 +: 32]      = swap32(key[i*64 + 32 +: 32]);
         od[i*32 +: 32]      = swap32(key[i*64 +: 32]);
         skw[(3-i)*32 +: 32] = rs_rem(swap32(key[i*64 + 32 +: 32]),
                                      swap32(key[i*64 +: 32]));
      end
   end

   assign ib = {cnt_ff[5:1], 1'b0, 2'b00} >> 2;
   assign ha = h_byte(2'd0, ib, ev) ^ h_byte(2'd1, ib, ev) ^
               h_byte(2'd2, ib, ev) ^ h_byte(2'd3, ib, ev);
   assign hb = h_byte(2'd0, ib + 8'd1, od) ^ h_byte(2'd1, ib + 8'd1, od) ^
               h_byte(2'd2, ib + 8'd1, od) ^ h_byte(2'd3, ib + 8'd1, od);
   assign s0 = a_ff + b_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      wr       = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SUBA;
               cnt_in   = '0;
            end
         end
         ST_SUBA: begin
            a_in     = ha;
            b_in     = {hb[23:0], hb[31:24]};
            state_in = ST_SUBB;
         end
         ST_SUBB: begin
            wr.sk_we   = 1'b1;
            wr.sk_addr = cnt_ff[5:0];
            wr.sk_data = s0;
            a_in       = a_ff + {b_ff[30:0], 1'b0};
            if (cnt_ff[0]) begin
               wr.sk_data = {a_ff[22:0], a_ff[31:23]};
               if (cnt_ff[5:0] == 6'(NumSubkeys - 1)) begin
                  state_in = ST_SBOX;
                  cnt_in   = '0;
               end else begin
                  state_in = ST_SUBA;
                  cnt_in   = cnt_ff + 10'd1;
               end
            end else begin
               cnt_in = cnt_ff + 10'd1;
            end
         end
         ST_SBOX: begin
            wr.sb_we   = 1'b1;
            wr.sb_addr = cnt_ff;
            wr.sb_data = h_byte(cnt_ff[1:0], cnt_ff[9:2], skw);
            cnt_in     = cnt_ff + 10'd1;
            if (cnt_ff == 10'h3FF) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
   end

   assign busy = (state_ff != ST_IDLE);

endmodule
`default_nettype wire

/* rtl/core/tf256_round.sv */
// ----------------------------------------------------------------------------
// tf256_round
// Feistel datapath: keyed S-box memory read one lane pair per cycle, subkey
// memory, one half-round at a time.
// ----------------------------------------------------------------------------
`default_nettype none
module tf256_round
   import tf256_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  ks_write_type   wr,
   input  wire logic      start,
   input  req_payload_type blk,
   output logic           done,
   output rsp_payload_type res
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_WIN  = 5'b00010,
      ST_RD   = 5'b00100,
      ST_CALC = 5'b01000,
      ST_WOUT = 5'b10000
   } state_type;

   logic [31:0] sk_mem [NumSubkeys];
   logic [31:0] sb_mem [1024];

   state_type   state_ff, state_in;
   logic [31:0] w_ff [4];
   logic [31:0] w_in [4];
   logic        dec_ff, dec_in;
   logic [4:0]  half_ff, half_in;
   logic [2:0]  sub_ff, sub_in;
   logic [5:0]  sk_ra;
   logic [31:0] sk_rd_ff;
   logic [31:0] k_ff [2];
   logic [9:0]  sb_ra0, sb_ra1;
   logic [31:0] sb_rd0_ff, sb_rd1_ff;
   logic [31:0] t0_ff, t1_ff;
   logic [31:0] xa, xb, f0, f1;
   logic [3:0]  rnd;
   logic [5:0]  kb;

   always_ff @(posedge clock) begin
      if (wr.sk_we) sk_mem[wr.sk_addr] <= wr.sk_data;
      if (wr.sb_we) sb_mem[wr.sb_addr] <= wr.sb_data;
      sk_rd_ff  <= sk_mem[sk_ra];
      sb_rd0_ff <= sb_mem[sb_ra0];
      sb_rd1_ff <= sb_mem[sb_ra1];
   end

   assign rnd = dec_ff ? 4'(15 - half_ff[3:0]) : half_ff[3:0];
   assign kb  = 6'd8 + {1'b0, rnd, 1'b0};
   assign xa  = half_ff[0] ? w_ff[2] : w_ff[0];
   assign xb  = half_ff[0] ? w_ff[3] : w_ff[1];

   // lane j per cycle: g0 takes byte j, g1 takes byte j-1
   assign sb_ra0 = {xa[{sub_ff[1:0], 3'b000} +: 8], sub_ff[1:0]};
   assign sb_ra1 = {xb[{sub_ff[1:0] - 2'd1, 3'b000} +: 8], sub_ff[1:0]};

   always_comb begin
      case (state_ff)
         ST_WIN:  sk_ra = {4'b0000, sub_ff[1:0]} + (dec_ff ? 6'd4 : 6'd0);
         ST_WOUT: sk_ra = {4'b0000, sub_ff[1:0]} + (dec_ff ? 6'd0 : 6'd4);
         default: sk_ra = kb + {5'b00000, sub_ff[0]};
      endcase
   end

   assign f0 = t0_ff + t1_ff + k_ff[0];
   assign f1 = t0_ff + {t1_ff[30:0], 1'b0} + k_ff[1];

   always_comb begin
      logic [31:0] c, d, cn, dn;
      state_in = state_ff;
      dec_in   = dec_ff;
      half_in  = half_ff;
      sub_in   = sub_ff;
      for (int i = 0; i < 4; i++) w_in[i] = w_ff[i];
      c  = half_ff[0] ? w_ff[0] : w_ff[2];
      d  = half_ff[0] ? w_ff[1] : w_ff[3];
      if (!dec_ff) begin
         cn = c ^ f0;  cn = {cn[0], cn[31:1]};
         dn = {d[30:0], d[31]} ^ f1;
      end else begin
         cn = {c[30:0], c[31]} ^ f0;
         dn = d ^ f1;  dn = {dn[0], dn[31:1]};
      end
      done = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               dec_in   = blk.command;
               w_in[0]  = swap32(blk.in_word0);
               w_in[1]  = swap32(blk.in_word1);
               w_in[2]  = swap32(blk.in_word2);
               w_in[3]  = swap32(blk.in_word3);
               sub_in   = '0;
               state_in = ST_WIN;
            end
         end
         ST_WIN: begin
            sub_in = sub_ff + 3'd1;
            if (sub_ff != 3'd0) w_in[sub_ff[1:0] - 2'd1] = w_ff[sub_ff[1:0] - 2'd1] ^ sk_rd_ff;
            if (sub_ff == 3'd4) begin
               w_in[3]  = w_ff[3] ^ sk_rd_ff;
               half_in  = '0;
               sub_in   = '0;
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            sub_in = sub_ff + 3'd1;
            if (sub_ff == 3'd4) begin
               sub_in   = '0;
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            if (half_ff[0]) begin
               w_in[0] = cn; w_in[1] = dn;
            end else begin
               w_in[2] = cn; w_in[3] = dn;
            end
            half_in = half_ff + 5'd1;
            if (half_ff == 5'd15) state_in = ST_WOUT;
            else state_in = ST_RD;
         end
         ST_WOUT: begin
            sub_in = sub_ff + 3'd1;
            if (sub_ff != 3'd0)
               w_in[(sub_ff[1:0] + 2'd1)] = w_ff[(sub_ff[1:0] + 2'd1)] ^ sk_rd_ff;
            if (sub_ff == 3'd4) begin
               w_in[1]  = w_ff[1] ^ sk_rd_ff;
               state_in = ST_IDLE;
               done     = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      dec_ff  <= dec_in;
      half_ff <= half_in;
      sub_ff  <= sub_in;
      for (int i = 0; i < 4; i++) w_ff[i] <= w_in[i];
      if (state_ff == ST_RD && (sub_ff == 3'd1 || sub_ff == 3'd2)) k_ff[sub_ff[1]] <= sk_rd_ff;
      if (state_ff == ST_RD && sub_ff != 3'd0) begin
         t0_ff <= (sub_ff == 3'd1) ? sb_rd0_ff : t0_ff ^ sb_rd0_ff;
         t1_ff <= (sub_ff == 3'd1) ? sb_rd1_ff : t1_ff ^ sb_rd1_ff;
      end
   end

   assign res.out_word0 = swap32(w_in[2]);
   assign res.out_word1 = swap32(w_in[3]);
   assign res.out_word2 = swap32(w_in[0]);
   assign res.out_word3 = swap32(w_in[1]);

endmodule
`default_nettype wire
